[rtl/frts_pkg.sv]
// ----------------------------------------------------------------------------
// frts_pkg
// Shared constants, codes and types for the fractional-rate task scheduler.
// ----------------------------------------------------------------------------
package frts_pkg;

    localparam int TASKS = 16;
    localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CNT_W = $clog2(TASKS + 1);

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_ADD  = 2'd1;
    localparam logic [1:0] FUNC_MOD  = 2'd2;
    localparam logic [1:0] FUNC_REM  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [3:0] MODE_FIXED = 4'd0;
    localparam logic [3:0] MODE_VAR   = 4'd1;

    localparam logic [17:0] RATE_ONE  = 18'h10000;
    localparam logic signed [26:0] PHASE_ONE = 27'sh10000;
    localparam logic signed [26:0] PHASE_MAX = 27'sh1FFFFFF;

    typedef struct packed {
        logic [7:0]         prio;
        logic [17:0]        rate;
        logic [3:0]         mode;
        logic signed [25:0] phase;
        logic [31:0]        bank;
        logic [15:0]        id;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec_op;
        logic eval;
        logic div_step;
        logic push;
        logic flush;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic       is_tick;
        logic       idx_end;
        logic       ev_fire;
        logic       ev_div;
        logic       div_done;
        logic       out_free;
        logic       pend_vld;
    } t_sts;

endpackage

[rtl/frts_ctrl.sv]
// ----------------------------------------------------------------------------
// frts_ctrl
// Sequencer: accepts a command word, walks the table on a tick, runs the
// divider per non-saturating fixed-mode firing, feeds the output register.
// ----------------------------------------------------------------------------
module frts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  frts_pkg::t_sts i_sts,
    output frts_pkg::t_ctl o_ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.is_tick) begin
                    n_state = S_EVAL;
                end else begin
                    o_ctl.exec_op = 1'b1;
                    n_state       = S_FLUSH;
                end
            end
            S_EVAL: begin
                if (i_sts.idx_end) begin
                    n_state = S_FLUSH;
                end else begin
                    o_ctl.eval = 1'b1;
                    if (i_sts.ev_div) begin
                        n_state = S_DIV;
                    end else if (i_sts.ev_fire) begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_sts.out_free || !i_sts.pend_vld) begin
                    o_ctl.push = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_ctl.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_done) |=> (r_state == S_PUSH))
        else $error("divider exit missed");
    a_accept_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_state == S_START))
        else $error("load outside idle");
    a_flush_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.flush |=> o_s_tready)
        else $error("flush did not return to idle");

endmodule

[rtl/frts_datapath.sv]
// ----------------------------------------------------------------------------
// frts_datapath
// Task table, phase/bank update, restoring divider, pending and output words.
// ----------------------------------------------------------------------------
module frts_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_func,
    input  logic [31:0]    i_sim_step,
    input  logic [31:0]    i_frame_time,
    input  logic [7:0]     i_priority_req,
    input  logic [17:0]    i_rate,
    input  logic [23:0]    i_phase_delay,
    input  logic [3:0]     i_mode,
    input  logic [15:0]    i_target_handle,
    input  frts_pkg::t_ctl i_ctl,
    output frts_pkg::t_sts o_sts,
    input  logic           i_m_tready,
    output logic           o_m_tvalid,
    output logic           o_m_tlast,
    output logic [15:0]    o_task_handle,
    output logic           o_fired,
    output logic [31:0]    o_delta_time,
    output logic [1:0]     o_status
);

    frts_pkg::t_entry r_ent [frts_pkg::TASKS];
    logic [frts_pkg::CNT_W-1:0] r_count;
    logic [15:0] r_next_id;

    logic [1:0]  r_func;
    logic [31:0] r_sim, r_rnd;
    logic [7:0]  r_prio;
    logic [17:0] r_rate;
    logic [23:0] r_offs;
    logic [3:0]  r_mode;
    logic [15:0] r_tgt;

    logic [frts_pkg::CNT_W-1:0] r_idx;

    logic [17:0] r_rem;
    logic [31:0] r_dvd;
    logic [31:0] r_quo;
    logic [17:0] r_drate;
    logic [4:0]  r_dcnt;

    logic [15:0] r_cand_id;
    logic [31:0] r_cand_dt;

    logic        r_pend_vld;
    logic [15:0] r_pend_h;
    logic        r_pend_fired;
    logic [31:0] r_pend_dt;
    logic [1:0]  r_pend_st;

    logic        r_out_vld;
    logic        r_out_last;
    logic [15:0] r_out_h;
    logic        r_out_fired;
    logic [31:0] r_out_dt;
    logic [1:0]  r_out_st;

    // current entry evaluation
    frts_pkg::t_entry   e;
    logic signed [26:0] p_sum;
    logic signed [26:0] p_sat;
    logic signed [26:0] p_new;
    logic               p_fire;
    logic [32:0]        b_sum;
    logic [31:0]        b_sat;
    logic               ev_run;
    logic               ev_fire;
    logic               ev_sat;

    // divider step
    logic [18:0] d_t;
    logic        d_ge;
    logic [18:0] d_sub;

    // add / lookup
    logic [frts_pkg::CNT_W-1:0] ins_pos;
    logic [frts_pkg::CNT_W-1:0] hit_pos;
    logic                       hit;
    logic [15:0]                id_inc;
    logic                       out_free;

    assign e      = r_ent[r_idx[frts_pkg::IDX_W-1:0]];
    assign p_sum  = {e.phase[25], e.phase} + $signed({9'b0, e.rate});
    assign p_sat  = (p_sum > frts_pkg::PHASE_MAX) ? frts_pkg::PHASE_MAX : p_sum;
    assign p_fire = (p_sat >= frts_pkg::PHASE_ONE);
    assign p_new  = p_fire ? (p_sat - frts_pkg::PHASE_ONE) : p_sat;
    assign b_sum  = {1'b0, e.bank} + {1'b0, r_rnd};
    assign b_sat  = b_sum[32] ? 32'hFFFF_FFFF : b_sum[31:0];
    assign ev_run = (e.rate != 18'd0) &&
                    ((e.mode == frts_pkg::MODE_FIXED) ||
                     ((e.mode == frts_pkg::MODE_VAR) && (r_rnd != 32'd0)));
    assign ev_fire = ev_run && p_fire;
    // quotient overflows 32 bits exactly when sim[31:16] >= rate
    assign ev_sat  = ({2'b0, r_sim[31:16]} >= e.rate);

    assign d_t   = {r_rem, r_dvd[31]};
    assign d_sub = d_t - {1'b0, r_drate};
    assign d_ge  = (d_t >= {1'b0, r_drate});

    assign id_inc   = r_next_id + 16'd1;
    assign out_free = !r_out_vld || i_m_tready;

    always_comb begin
        ins_pos = r_count;
        hit     = 1'b0;
        hit_pos = '0;
        for (int k = frts_pkg::TASKS - 1; k >= 0; k--) begin
            if ((frts_pkg::CNT_W'(k) < r_count) && !(r_ent[k].prio < r_prio)) begin
                ins_pos = frts_pkg::CNT_W'(k);
            end
            if ((frts_pkg::CNT_W'(k) < r_count) && (r_ent[k].id == r_tgt)) begin
                hit     = 1'b1;
                hit_pos = frts_pkg::CNT_W'(k);
            end
        end
    end

    assign o_sts.is_tick  = (r_func == frts_pkg::FUNC_TICK);
    assign o_sts.idx_end  = (r_idx >= r_count);
    assign o_sts.ev_fire  = ev_fire;
    assign o_sts.ev_div   = ev_fire && (e.mode == frts_pkg::MODE_FIXED) && !ev_sat;
    assign o_sts.div_done = (r_dcnt == 5'd31);
    assign o_sts.out_free = out_free;
    assign o_sts.pend_vld = r_pend_vld;

    // table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_next_id <= 16'd1;
        end else if (i_ctl.eval && ev_run) begin
            r_ent[r_idx[frts_pkg::IDX_W-1:0]].phase <= p_new[25:0];
            if (e.mode == frts_pkg::MODE_VAR) begin
                r_ent[r_idx[frts_pkg::IDX_W-1:0]].bank <= p_fire ? 32'd0 : b_sat;
            end
        end else if (i_ctl.exec_op) begin
            case (r_func)
                frts_pkg::FUNC_ADD: begin
                    if (r_count != frts_pkg::CNT_W'(frts_pkg::TASKS)) begin
                        for (int k = 1; k < frts_pkg::TASKS; k++) begin
                            if ((frts_pkg::CNT_W'(k) > ins_pos) &&
                                (frts_pkg::CNT_W'(k) <= r_count)) begin
                                r_ent[k] <= r_ent[k-1];
                            end
                        end
                        r_ent[ins_pos[frts_pkg::IDX_W-1:0]] <= '{
                            prio:  r_prio,
                            rate:  (r_rate > frts_pkg::RATE_ONE) ? frts_pkg::RATE_ONE : r_rate,
                            mode:  r_mode,
                            phase: -$signed({2'b0, r_offs}),
                            bank:  32'd0,
                            id:    r_next_id
                        };
                        r_count   <= r_count + 1'b1;
                        r_next_id <= (id_inc == 16'd0) ? 16'd1 : id_inc;
                    end
                end
                frts_pkg::FUNC_MOD: begin
                    if (hit) begin
                        r_ent[hit_pos[frts_pkg::IDX_W-1:0]].rate <= r_rate;
                    end
                end
                frts_pkg::FUNC_REM: begin
                    if (hit) begin
                        for (int k = 0; k < frts_pkg::TASKS - 1; k++) begin
                            if ((frts_pkg::CNT_W'(k) >= hit_pos) &&
                                (frts_pkg::CNT_W'(k + 1) < r_count)) begin
                                r_ent[k] <= r_ent[k+1];
                            end
                        end
                        r_count <= r_count - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // input latch, walk index, divider, candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_ctl.load) begin
                r_func <= i_func;
                r_sim  <= i_sim_step;
                r_rnd  <= i_frame_time;
                r_prio <= i_priority_req;
                r_rate <= i_rate;
                r_offs <= i_phase_delay;
                r_mode <= i_mode;
                r_tgt  <= i_target_handle;
                r_idx  <= '0;
            end
            if (i_ctl.eval) begin
                r_cand_id <= e.id;
                r_cand_dt <= (e.mode == frts_pkg::MODE_FIXED) ? 32'hFFFF_FFFF : b_sat;
                r_rem     <= {2'b0, r_sim[31:16]};
                r_dvd     <= {r_sim[15:0], 16'h0};
                r_drate   <= e.rate;
                r_dcnt    <= '0;
                if (!ev_fire) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_ctl.div_step) begin
                r_rem  <= d_ge ? d_sub[17:0] : d_t[17:0];
                r_dvd  <= {r_dvd[30:0], 1'b0};
                r_quo  <= {r_quo[30:0], d_ge};
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == 5'd31) begin
                    r_cand_dt <= {r_quo[30:0], d_ge};
                end
            end
            if (i_ctl.push) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // pending word and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if ((i_ctl.push && r_pend_vld) || i_ctl.flush) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_ctl.load) begin
                r_pend_vld <= 1'b0;
            end
            if (i_ctl.exec_op) begin
                r_pend_vld   <= 1'b1;
                r_pend_fired <= 1'b0;
                r_pend_dt    <= 32'd0;
                if (r_func == frts_pkg::FUNC_ADD) begin
                    if (r_count == frts_pkg::CNT_W'(frts_pkg::TASKS)) begin
                        r_pend_h  <= 16'd0;
                        r_pend_st <= frts_pkg::ST_FULL;
                    end else begin
                        r_pend_h  <= r_next_id;
                        r_pend_st <= frts_pkg::ST_OK;
                    end
                end else if (hit) begin
                    r_pend_h  <= r_tgt;
                    r_pend_st <= frts_pkg::ST_OK;
                end else begin
                    r_pend_h  <= 16'd0;
                    r_pend_st <= frts_pkg::ST_UNKNOWN;
                end
            end
            if (i_ctl.push) begin
                if (r_pend_vld) begin
                    r_out_last  <= 1'b0;
                    r_out_h     <= r_pend_h;
                    r_out_fired <= r_pend_fired;
                    r_out_dt    <= r_pend_dt;
                    r_out_st    <= r_pend_st;
                end
                r_pend_vld   <= 1'b1;
                r_pend_h     <= r_cand_id;
                r_pend_fired <= 1'b1;
                r_pend_dt    <= r_cand_dt;
                r_pend_st    <= frts_pkg::ST_OK;
            end
            if (i_ctl.flush) begin
                r_out_last  <= 1'b1;
                r_out_h     <= r_pend_vld ? r_pend_h : 16'd0;
                r_out_fired <= r_pend_vld ? r_pend_fired : 1'b0;
                r_out_dt    <= r_pend_vld ? r_pend_dt : 32'd0;
                r_out_st    <= r_pend_vld ? r_pend_st : frts_pkg::ST_OK;
                r_pend_vld  <= 1'b0;
            end
        end
    end

    assign o_m_tvalid    = r_out_vld;
    assign o_m_tlast     = r_out_last;
    assign o_task_handle = r_out_h;
    assign o_fired       = r_out_fired;
    assign o_delta_time  = r_out_dt;
    assign o_status      = r_out_st;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= frts_pkg::CNT_W'(frts_pkg::TASKS))
        else $error("task count out of range");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && r_pend_vld) |-> out_free)
        else $error("pending word pushed over a held output");
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.flush |=> (r_out_vld && r_out_last && !r_pend_vld))
        else $error("flush did not produce final word");

endmodule

[rtl/fractional_rate_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// fractional_rate_task_scheduler_top
// Fractional-rate task scheduler with a priority-ordered task table.
// ----------------------------------------------------------------------------
// Input stream (s_*): one word per command. tuser carries func (tick, add,
// modify rate, remove); tdata carries the operands. tready is high only while
// the scheduler is idle, so commands are processed one at a time.
// Output stream (m_*): one or more words per command, tlast on the final one.
// tuser flags a firing; tdata carries handle, time step and status.
// Add/modify/remove execute in the start state and present their word from
// the flush state. A tick walks the table one entry at a time, with a push
// state per firing, and runs the shared restoring divider for each
// fixed-mode firing that needs a quotient (one bit per cycle, 32 bits).
// Firing words are held one deep so the final one can carry tlast; a stalled
// receiver simply holds the walk at the next firing or at the end.
// Reset (synchronous, active low) empties the table and restarts handles at 1.
// ----------------------------------------------------------------------------
module fractional_rate_task_scheduler_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // sim_step[31:0], frame_time[63:32], priority_req[71:64], rate[89:72],
    // phase_delay[113:90], mode[117:114], target_handle[133:118], zero fill
    input  logic [135:0] i_s_tdata,
    // func[1:0]
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // task_handle[15:0], delta_time[47:16], status[49:48], zero fill
    output logic [55:0]  o_m_tdata,
    // fired[0]
    output logic         o_m_tuser,
    output logic         o_m_tlast
);

    frts_pkg::t_ctl w_ctl;
    frts_pkg::t_sts w_sts;
    logic [15:0] w_handle;
    logic [31:0] w_dt;
    logic [1:0]  w_status;

    frts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    frts_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_func          (i_s_tuser),
        .i_sim_step      (i_s_tdata[31:0]),
        .i_frame_time    (i_s_tdata[63:32]),
        .i_priority_req  (i_s_tdata[71:64]),
        .i_rate          (i_s_tdata[89:72]),
        .i_phase_delay   (i_s_tdata[113:90]),
        .i_mode          (i_s_tdata[117:114]),
        .i_target_handle (i_s_tdata[133:118]),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_m_tlast       (o_m_tlast),
        .o_task_handle   (w_handle),
        .o_fired         (o_m_tuser),
        .o_delta_time    (w_dt),
        .o_status        (w_status)
    );

    assign o_m_tdata = {6'b0, w_status, w_dt, w_handle};

endmodule
